### hdl/esl_pkg.sv
// esl_pkg: shared types, character codes and helpers for the line splitter
// used by esl_front, esl_queue, esl_back, escaped_line_splitter and esl_checker
// no dependencies
package esl_pkg;

	// width of the internal physical line counter
	localparam int COUNT_BITS = 16;
	// width of the reported line count
	localparam int OUT_BITS = 16;
	// queue depth between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

	// character codes
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;

	// partner byte to drop after a newline
	typedef enum logic [1:0] {
		SW_NONE = 2'd0,
		SW_CR   = 2'd1,
		SW_LF   = 2'd2
	} esl_swallow_t;

	// work for the back end: an optional leading backslash, then a byte or a line end
	typedef struct packed {
		logic                two;
		logic                is_end;
		logic [7:0]          data;
		logic [OUT_BITS-1:0] count;
	} esl_cmd_t;

	// clamp the internal count to the reported width
	function automatic logic [OUT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_BITS-1:0] w;
		w = (COUNT_BITS + OUT_BITS)'(v);
		if (w > (COUNT_BITS + OUT_BITS)'(OUT_MAX)) begin
			return OUT_MAX;
		end
		return w[OUT_BITS-1:0];
	endfunction

endpackage

### hdl/esl_front.sv
// esl_front: accepts bytes, tracks quoting, comment and line state, issues work
// depends on esl_pkg
module esl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        in_byte,
	input  logic              end_of_input,
	output logic              push,
	output esl_pkg::esl_cmd_t cmd
);
	import esl_pkg::*;

	logic                  quote_q, quote_d;
	logic                  comment_q, comment_d;
	esl_swallow_t          swallow_q, swallow_d;
	logic [COUNT_BITS-1:0] lines_q, lines_d;
	logic                  any_q, any_d;
	logic                  sw_hit;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q   <= 1'b0;
			comment_q <= 1'b0;
			swallow_q <= SW_NONE;
			lines_q   <= COUNT_BITS'(1);
			any_q     <= 1'b0;
		end else if (fire) begin
			quote_q   <= quote_d;
			comment_q <= comment_d;
			swallow_q <= swallow_d;
			lines_q   <= lines_d;
			any_q     <= any_d;
		end
	end

	// byte is the partner of the newline just before it
	always_comb begin
		case (swallow_q)
			SW_CR:   sw_hit = (in_byte == CH_CR);
			SW_LF:   sw_hit = (in_byte == CH_LF);
			default: sw_hit = 1'b0;
		endcase
	end

	// classify the byte and work out the next state
	always_comb begin
		quote_d    = quote_q;
		comment_d  = comment_q;
		swallow_d  = SW_NONE;
		lines_d    = lines_q;
		any_d      = any_q;
		push       = 1'b0;
		cmd.two    = 1'b0;
		cmd.is_end = 1'b0;
		cmd.data   = in_byte;
		cmd.count  = '0;
		if (end_of_input) begin
			// flush a pending backslash, close the line
			push       = fire;
			cmd.two    = quote_q;
			cmd.is_end = 1'b1;
			cmd.count  = any_q ? sat_count(lines_q) : '0;
			quote_d    = 1'b0;
			comment_d  = 1'b0;
			lines_d    = COUNT_BITS'(1);
			any_d      = 1'b0;
		end else if (!sw_hit) begin
			any_d = 1'b1;
			if (quote_q) begin
				quote_d = 1'b0;
				if (in_byte == CH_HASH) begin
					push = fire;
				end else if (in_byte == CH_CR || in_byte == CH_LF) begin
					// escaped newline continues the line
					swallow_d = (in_byte == CH_CR) ? SW_LF : SW_CR;
					if (lines_q != COUNT_MAX) begin
						lines_d = lines_q + COUNT_BITS'(1);
					end
				end else begin
					push    = fire;
					cmd.two = 1'b1;
				end
			end else begin
				if (in_byte == CH_HASH) begin
					comment_d = 1'b1;
				end else if (in_byte == CH_BSL) begin
					if (!comment_q) begin
						quote_d = 1'b1;
					end
				end else if (in_byte == CH_LF) begin
					// plain newline ends the line
					push       = fire;
					cmd.is_end = 1'b1;
					cmd.count  = sat_count(lines_q);
					quote_d    = 1'b0;
					comment_d  = 1'b0;
					lines_d    = COUNT_BITS'(1);
					any_d      = 1'b0;
					swallow_d  = SW_CR;
				end else if (!comment_q) begin
					push = fire;
				end
			end
		end
	end

endmodule

### hdl/esl_queue.sv
// esl_queue: short first-in first-out store of work between front and back
// depends on esl_pkg
module esl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  esl_pkg::esl_cmd_t push_data,
	output logic              not_full,
	input  logic              pop,
	output logic              not_empty,
	output esl_pkg::esl_cmd_t pop_data
);
	import esl_pkg::*;

	esl_cmd_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;
	logic                      do_push;
	logic                      do_pop;

	assign not_full  = (cnt_q != QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

endmodule

### hdl/esl_back.sv
// esl_back: turns queued work into results, one result per cycle while work is queued and the receiver is ready
// depends on esl_pkg
module esl_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_not_empty,
	input  esl_pkg::esl_cmd_t            q_data,
	output logic                         q_pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [7:0]                   out_byte,
	output logic                         is_line_end,
	output logic [esl_pkg::OUT_BITS-1:0] line_count,
	output logic                         last
);
	import esl_pkg::*;

	esl_cmd_t cur_q;
	logic     valid_q;
	logic     second_q;
	logic     lead_bsl;
	logic     take;
	logic     advance;

	assign lead_bsl     = cur_q.two && !second_q;
	assign take         = valid_q && result_ready;
	assign advance      = !valid_q || (take && !lead_bsl);
	assign q_pop        = advance && q_not_empty;
	assign result_valid = valid_q;

	// current work and which of its results is shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (advance) begin
			valid_q  <= q_not_empty;
			second_q <= 1'b0;
		end else if (take) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cur_q <= q_data;
		end
	end

	// result fields
	always_comb begin
		if (lead_bsl) begin
			out_byte    = CH_BSL;
			is_line_end = 1'b0;
			line_count  = '0;
			last        = 1'b0;
		end else if (cur_q.is_end) begin
			out_byte    = 8'h00;
			is_line_end = 1'b1;
			line_count  = cur_q.count;
			last        = 1'b1;
		end else begin
			out_byte    = cur_q.data;
			is_line_end = 1'b0;
			line_count  = '0;
			last        = 1'b1;
		end
	end

endmodule

### hdl/escaped_line_splitter.sv
// escaped_line_splitter: top level of the logical line splitter
// depends on esl_pkg, esl_front, esl_queue, esl_back
//
// Takes one byte of text (or an end-of-input mark) per item and gives the bytes
// of each logical line followed by a line-end result carrying the physical line
// count. The front end takes a new item every cycle while its two-entry queue has
// room; the back end presents one result per cycle from its output register while
// the receiver is ready, so an item that expands to a backslash plus a byte or line
// end gives two results in turn. Silent items (comment bytes, escapes, dropped
// newline partners) give no result. An item's first result is registered in the
// queue and then in the back end's output register.
module escaped_line_splitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [7:0]                   in_byte,
	input  logic                         end_of_input,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [7:0]                   out_byte,
	output logic                         is_line_end,
	output logic [esl_pkg::OUT_BITS-1:0] line_count,
	output logic                         last
);
	import esl_pkg::*;

	logic     fire;
	logic     push;
	esl_cmd_t cmd;
	logic     q_not_full;
	logic     q_not_empty;
	logic     q_pop;
	esl_cmd_t q_data;

	assign item_ready = q_not_full;
	assign fire       = item_valid && item_ready;

	// classification and line state
	esl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.cmd          (cmd)
	);

	// decoupling queue
	esl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	// result generation
	esl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.is_line_end  (is_line_end),
		.line_count   (line_count),
		.last         (last)
	);

endmodule

### hdl/esl_checker.sv
// esl_checker: port-level assertions for escaped_line_splitter, bound to the top
// depends on esl_pkg and escaped_line_splitter
module esl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic [7:0]                   in_byte,
	input logic                         end_of_input,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [7:0]                   out_byte,
	input logic                         is_line_end,
	input logic [esl_pkg::OUT_BITS-1:0] line_count,
	input logic                         last
);
	import esl_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_byte)
			&& $stable(is_line_end) && $stable(line_count) && $stable(last))
		else $error("stalled result changed");

	// a line end is always the final result of its item and carries no byte
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_line_end |-> last && out_byte == 8'h00)
		else $error("malformed line end");

	// data results carry no count
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_line_end |-> line_count == '0)
		else $error("count on data result");

	// a non-final result is a backslash and its partner follows at once
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last |-> out_byte == CH_BSL ##1 result_valid)
		else $error("split result pair broken");

endmodule

bind escaped_line_splitter esl_checker u_esl_checker (.*);

### verif/escaped_line_splitter_tb.sv
// escaped_line_splitter_tb: self-checking bench for the logical line splitter
// drives bytes and end-of-input marks, predicts every line byte and line end
// depends on esl_pkg and escaped_line_splitter
module escaped_line_splitter_tb;
	import esl_pkg::*;

	localparam int RAND_ITEMS = 510;
	localparam int LIMIT = 2000000;

	// one result of the block: a line byte or a line end
	typedef struct packed {
		logic [7:0]          data;
		logic                is_end;
		logic [OUT_BITS-1:0] count;
		logic                last;
	} line_part_t;

	// one row of stimulus, with results typed in where they are obvious
	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
		logic       typed;
		logic [1:0] n;
		line_part_t e0;
		line_part_t e1;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [7:0] in_byte = 8'h00;
	logic end_of_input = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [7:0] out_byte;
	logic is_line_end;
	logic [OUT_BITS-1:0] line_count;
	logic last;

	// predicted splitter state
	logic quoting = 1'b0;
	logic in_comment = 1'b0;
	esl_swallow_t drop_next = SW_NONE;
	logic [COUNT_BITS-1:0] phys_lines = COUNT_BITS'(1);
	logic line_started = 1'b0;

	line_part_t line_parts_q[$];
	line_part_t step_parts[$];
	stim_row_t dir_rows[$];
	stim_row_t cur_row = '0;
	line_part_t got, want;

	logic in_take = 1'b0;
	logic calm = 1'b0;
	logic burst = 1'b0;
	int bad_count = 0;
	int cycles = 0;
	int rx_hold = 0;
	int sent = 0;

	escaped_line_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.is_line_end  (is_line_end),
		.line_count   (line_count),
		.last         (last)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic line_part_t byte_part(input logic [7:0] b, input logic fin);
		line_part_t r;
		r = '0;
		r.data = b;
		r.last = fin;
		return r;
	endfunction

	function automatic line_part_t fixed_end(input logic [OUT_BITS-1:0] c);
		line_part_t r;
		r = '0;
		r.is_end = 1'b1;
		r.count = c;
		r.last = 1'b1;
		return r;
	endfunction

	// line end from the predicted state; a line end is always the final part
	function automatic line_part_t end_part();
		logic [OUT_BITS-1:0] c;
		c = '0;
		if (line_started) begin
			c = (64'(phys_lines) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(phys_lines);
		end
		return fixed_end(c);
	endfunction

	function automatic void clear_line();
		quoting = 1'b0;
		in_comment = 1'b0;
		drop_next = SW_NONE;
		phys_lines = COUNT_BITS'(1);
		line_started = 1'b0;
	endfunction

	// splitter prediction for one item; leaves its parts in step_parts
	function automatic void split_step(input logic [7:0] b, input logic eoi);
		line_part_t r [2];
		int n;
		int i;
		logic dropped;
		n = 0;
		dropped = 1'b0;
		step_parts.delete();
		if (eoi) begin
			if (quoting) begin
				r[n] = byte_part(CH_BSL, 1'b0);
				n++;
			end
			r[n] = end_part();
			n++;
			clear_line();
		end else begin
			// newline partner is dropped only when it is the very next byte
			if (drop_next == SW_CR) dropped = (b == CH_CR);
			if (drop_next == SW_LF) dropped = (b == CH_LF);
			drop_next = SW_NONE;
			if (!dropped) begin
				line_started = 1'b1;
				if (quoting) begin
					quoting = 1'b0;
					if (b == CH_HASH) begin
						r[n] = byte_part(CH_HASH, 1'b0);
						n++;
					end else if (b == CH_CR || b == CH_LF) begin
						drop_next = (b == CH_CR) ? SW_LF : SW_CR;
						if (phys_lines != COUNT_MAX) phys_lines++;
					end else begin
						r[0] = byte_part(CH_BSL, 1'b0);
						r[1] = byte_part(b, 1'b0);
						n = 2;
					end
				end else if (b == CH_HASH) begin
					in_comment = 1'b1;
				end else if (b == CH_BSL) begin
					if (!in_comment) quoting = 1'b1;
				end else if (b == CH_LF) begin
					r[n] = end_part();
					n++;
					clear_line();
					drop_next = SW_CR;
				end else if (!in_comment) begin
					r[n] = byte_part(b, 1'b0);
					n++;
				end
			end
		end
		if (n > 0) r[n-1].last = 1'b1;
		for (i = 0; i < n; i++) step_parts.push_back(r[i]);
	endfunction

	function automatic stim_row_t typed_row(input logic [7:0] b, input logic eoi,
			input logic [1:0] n, input line_part_t e0, input line_part_t e1);
		stim_row_t r;
		r.b = b;
		r.eoi = eoi;
		r.typed = 1'b1;
		r.n = n;
		r.e0 = e0;
		r.e1 = e1;
		return r;
	endfunction

	function automatic stim_row_t plain_row(input logic [7:0] b, input logic eoi);
		stim_row_t r;
		r = '0;
		r.b = b;
		r.eoi = eoi;
		return r;
	endfunction

	// idle length: mostly none, sometimes short, rarely long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sample handshakes and outputs away from the driving edge
	always @(negedge clk) begin
		in_take = item_valid && item_ready;
		if (arst_n) begin
			if (in_take) begin
				split_step(in_byte, end_of_input);
				if (cur_row.typed) begin
					if (cur_row.n > 0) line_parts_q.push_back(cur_row.e0);
					if (cur_row.n > 1) line_parts_q.push_back(cur_row.e1);
				end else begin
					while (step_parts.size() != 0) line_parts_q.push_back(step_parts.pop_front());
				end
			end
			if (result_valid && result_ready) begin
				got.data = out_byte;
				got.is_end = is_line_end;
				got.count = line_count;
				got.last = last;
				if (line_parts_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10) begin
						$display("unexpected item: byte %02h end %0d count %0d last %0d",
							got.data, got.is_end, got.count, got.last);
					end
				end else begin
					want = line_parts_q.pop_front();
					if (got != want) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("mismatch: got byte %02h end %0d count %0d last %0d",
								got.data, got.is_end, got.count, got.last);
							$display("          want byte %02h end %0d count %0d last %0d",
								want.data, want.is_end, want.count, want.last);
						end
					end
				end
			end
		end
	end

	// quiet stretches with no idling on either side
	always begin
		repeat ($urandom_range(50, 300)) @(negedge clk);
		calm = ($urandom_range(0, 3) == 0);
	end

	// receiver stalls
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			rx_hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("escaped_line_splitter_tb NOT OK");
			$finish;
		end
	end

	// offer one item and wait for its handshake; drain holds off until all results are in
	task automatic send_row(input stim_row_t r, input logic drain);
		int gap;
		gap = burst ? 0 : idle_len();
		if (gap > 0 || drain) begin
			item_valid <= 1'b0;
			@(posedge clk);
			repeat (gap - 1) @(posedge clk);
			while (drain && line_parts_q.size() != 0) @(posedge clk);
		end
		cur_row = r;
		item_valid <= 1'b1;
		in_byte <= r.b;
		end_of_input <= r.eoi;
		do @(posedge clk); while (!in_take);
	endtask

	task automatic send_rand(input logic [7:0] b, input logic eoi);
		send_row(plain_row(b, eoi), sent == RAND_ITEMS / 2);
		sent++;
	endtask

	initial begin
		int i;
		int pick;
		// directed rows
		dir_rows.push_back(typed_row(8'h00, 1'b1, 2'd1, fixed_end('0), '0));
		dir_rows.push_back(typed_row(8'hFF, 1'b1, 2'd1, fixed_end('0), '0));
		dir_rows.push_back(typed_row(8'h41, 1'b0, 2'd1, byte_part(8'h41, 1'b1), '0));
		dir_rows.push_back(typed_row(8'hFF, 1'b0, 2'd1, byte_part(8'hFF, 1'b1), '0));
		dir_rows.push_back(typed_row(8'h00, 1'b0, 2'd1, byte_part(8'h00, 1'b1), '0));
		dir_rows.push_back(typed_row(CH_LF, 1'b0, 2'd1, fixed_end(OUT_BITS'(1)), '0));
		dir_rows.push_back(typed_row(CH_CR, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_CR, 1'b0, 2'd1, byte_part(CH_CR, 1'b1), '0));
		dir_rows.push_back(typed_row(CH_LF, 1'b0, 2'd1, fixed_end(OUT_BITS'(1)), '0));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_HASH, 1'b0, 2'd1, byte_part(CH_HASH, 1'b1), '0));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'h7A, 1'b0, 2'd2, byte_part(CH_BSL, 1'b0),
			byte_part(8'h7A, 1'b1)));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_CR, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_LF, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_LF, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'h79, 1'b0, 2'd1, byte_part(8'h79, 1'b1), '0));
		dir_rows.push_back(typed_row(CH_HASH, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(plain_row(8'h71, 1'b0));
		dir_rows.push_back(typed_row(CH_LF, 1'b0, 2'd1, fixed_end(OUT_BITS'(3)), '0));
		dir_rows.push_back(typed_row(CH_BSL, 1'b0, 2'd0, '0, '0));
		dir_rows.push_back(typed_row(8'hA5, 1'b1, 2'd2, byte_part(CH_BSL, 1'b0),
			fixed_end(OUT_BITS'(1))));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) send_row(dir_rows[k], 1'b0);

		// a short run of quoted newlines, back to back
		burst = 1'b1;
		for (i = 0; i < 8; i++) begin
			send_row(plain_row(CH_BSL, 1'b0), 1'b0);
			send_row(plain_row(i[0] ? CH_LF : CH_CR, 1'b0), 1'b0);
		end
		send_row(plain_row(8'h00, 1'b1), 1'b0);
		burst = 1'b0;

		// random text made of lines, quotes, comments and newline pairs
		while (sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_rand(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 45) begin
				send_rand(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
			end else if (pick < 55) begin
				send_rand(CH_LF, 1'b0);
			end else if (pick < 59) begin
				send_rand(CH_CR, 1'b0);
			end else if (pick < 66) begin
				send_rand(CH_HASH, 1'b0);
			end else if (pick < 82) begin
				// quote and the quoted byte, sometimes with its newline partner
				send_rand(CH_BSL, 1'b0);
				case ($urandom_range(0, 5))
					0: send_rand(CH_HASH, 1'b0);
					1: send_rand(CH_BSL, 1'b0);
					2: begin
						send_rand(CH_CR, 1'b0);
						if ($urandom_range(0, 1)) send_rand(CH_LF, 1'b0);
					end
					3: begin
						send_rand(CH_LF, 1'b0);
						if ($urandom_range(0, 1)) send_rand(CH_CR, 1'b0);
					end
					4: send_rand(8'($urandom_range(0, 255)), 1'b1);
					default: send_rand(8'($urandom_range(0, 255)), 1'b0);
				endcase
			end else if (pick < 90) begin
				// newline pairs in either order
				if ($urandom_range(0, 1)) begin
					send_rand(CH_LF, 1'b0);
					send_rand(CH_CR, 1'b0);
				end else begin
					send_rand(CH_CR, 1'b0);
					send_rand(CH_LF, 1'b0);
				end
			end else if (pick < 95) begin
				send_rand(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_rand(CH_BSL, 1'b0);
			end
		end

		// let every expected item arrive, then watch for strays
		item_valid <= 1'b0;
		while (line_parts_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (bad_count == 0 && line_parts_q.size() == 0) begin
			$display("escaped_line_splitter_tb OK");
		end else begin
			$display("escaped_line_splitter_tb NOT OK");
		end
		$finish;
	end

endmodule

### escaped_line_splitter.f
hdl/esl_pkg.sv
hdl/esl_front.sv
hdl/esl_queue.sv
hdl/esl_back.sv
hdl/escaped_line_splitter.sv
hdl/esl_checker.sv
verif/escaped_line_splitter_tb.sv
